### rtl/csd_pkg.sv
// Shared types, codes and defaults for the CAN signal decoder.
// No dependencies; every other file but csd_ram imports this package.
package csd_pkg;

    localparam int DEF_MAX_MESSAGES  = 16;
    localparam int DEF_MAX_SIGNALS   = 64;
    localparam int DEF_PAYLOAD_BYTES = 64;

    // Motorola order: step back within a byte, else jump to the next byte's MSB
    localparam logic [10:0] MOTO_JUMP = 11'd15;
    localparam int          BYTE_BITS = 8;

    localparam logic [1:0] OP_DEF_MSG = 2'd0;
    localparam logic [1:0] OP_DEF_SIG = 2'd1;
    localparam logic [1:0] OP_LOAD    = 2'd2;
    localparam logic [1:0] OP_DECODE  = 2'd3;

    localparam logic [2:0] STAT_VALUE   = 3'd0;
    localparam logic [2:0] STAT_NOSIG   = 3'd1;
    localparam logic [2:0] STAT_UNKNOWN = 3'd2;
    localparam logic [2:0] STAT_SHORT   = 3'd3;
    localparam logic [2:0] STAT_OVF     = 3'd4;

    localparam logic [1:0] ROLE_SELECTOR = 2'd1;
    localparam logic [1:0] ROLE_MUXED    = 2'd2;

    typedef struct packed {
        logic [6:0]  count;
        logic [5:0]  first;
        logic [6:0]  len;
        logic        ext;
        logic [28:0] id;
    } msg_t;

    typedef struct packed {
        logic [16:0] mux_value;
        logic [1:0]  role;
        logic        is_signed;
        logic        lsb_first;
        logic [6:0]  width;
        logic [8:0]  pos;
    } sig_t;

    typedef struct packed {
        sig_t        layout;
        logic [63:0] factor;
        logic [63:0] offset;
    } sig_rec_t;

    typedef struct packed {
        logic [28:0] id;
        logic        ext;
        logic [6:0]  len;
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MSG_RD,
        ST_MSG_CMP,
        ST_SIG_CHK,
        ST_SIG_WAIT,
        ST_FETCH,
        ST_MUL,
        ST_NEG,
        ST_ADD,
        ST_EMIT_ONE,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } back_state_t;

endpackage

### rtl/csd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/csd_queue.sv
// Two-entry queue of decode requests between front and back.
// Depends on csd_pkg (req_t).
module csd_queue import csd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t wdata,
    input  logic pop,
    output req_t rdata,
    output logic full,
    output logic empty
);

    req_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### rtl/csd_front.sv
// Front end: accepts items, writes the definition tables and payload store,
// queues decode requests. Depends on csd_pkg.
module csd_front import csd_pkg::*; #(
    parameter int MAX_MESSAGES  = DEF_MAX_MESSAGES,
    parameter int MAX_SIGNALS   = DEF_MAX_SIGNALS,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
    parameter int MTW = $clog2(MAX_MESSAGES + 1),
    parameter int MAW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1,
    parameter int SAW = (MAX_SIGNALS > 1) ? $clog2(MAX_SIGNALS) : 1,
    parameter int PNW = PAYLOAD_BYTES / 8,
    parameter int PAW = (PNW > 1) ? $clog2(PNW) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      op,
    input  logic [28:0]     frame_id,
    input  logic            extended,
    input  logic [6:0]      byte_count,
    input  logic [8:0]      position,
    input  logic [6:0]      bit_count,
    input  logic            little_endian,
    input  logic            is_signed,
    input  logic [1:0]      mux_role,
    input  logic [16:0]     mux_value,
    input  logic [63:0]     wide_value,
    input  logic [63:0]     offset,
    input  logic            q_full,
    input  logic            q_empty,
    input  logic            back_idle,
    output logic            q_push,
    output req_t            q_wdata,
    output logic            msg_we,
    output logic [MAW-1:0]  msg_waddr,
    output msg_t            msg_wdata,
    output logic            sig_we,
    output logic [SAW-1:0]  sig_waddr,
    output sig_rec_t        sig_wdata,
    output logic            pay_we,
    output logic [PAW-1:0]  pay_waddr,
    output logic [63:0]     pay_wdata,
    output logic [PNW-1:0]  pay_valid,
    output logic [MTW-1:0]  msg_total
);

    logic [MTW-1:0] msg_total_reg;
    logic [6:0]     sig_total_reg;
    msg_t           last_msg_reg;
    logic [PNW-1:0] pay_valid_reg;
    logic           acc;
    logic           do_msg;
    logic           do_sig;
    logic           do_load;
    msg_t           new_msg;
    msg_t           bumped_msg;

    // tables change only with no decode pending anywhere
    assign in_ready = (op == OP_DECODE) ? !q_full : (q_empty && back_idle);
    assign acc      = in_valid && in_ready;

    assign do_msg  = acc && (op == OP_DEF_MSG) && (msg_total_reg < MAX_MESSAGES);
    assign do_sig  = acc && (op == OP_DEF_SIG) && (msg_total_reg != '0)
                     && (sig_total_reg < MAX_SIGNALS);
    assign do_load = acc && (op == OP_LOAD) && ({23'd0, position} < PNW);

    assign q_push  = acc && (op == OP_DECODE);
    assign q_wdata = '{id: frame_id, ext: extended, len: byte_count};

    always_comb
    begin
        new_msg       = '{count: 7'd0, first: sig_total_reg[5:0], len: byte_count,
                          ext: extended, id: frame_id};
        bumped_msg       = last_msg_reg;
        bumped_msg.count = last_msg_reg.count + 7'd1;
    end

    assign msg_we    = do_msg || do_sig;
    assign msg_waddr = do_msg ? msg_total_reg[MAW-1:0] : MAW'(msg_total_reg - 1'b1);
    assign msg_wdata = do_msg ? new_msg : bumped_msg;

    assign sig_we    = do_sig;
    assign sig_waddr = sig_total_reg[SAW-1:0];
    assign sig_wdata = '{layout: '{mux_value: mux_value, role: mux_role,
                                   is_signed: is_signed, lsb_first: little_endian,
                                   width: bit_count, pos: position},
                         factor: wide_value, offset: offset};

    assign pay_we    = do_load;
    assign pay_waddr = position[PAW-1:0];
    assign pay_wdata = wide_value;
    assign pay_valid = pay_valid_reg;
    assign msg_total = msg_total_reg;

    always_ff @(posedge clk)
    begin
        if (do_msg)
        begin
            last_msg_reg <= new_msg;
        end
        else if (do_sig)
        begin
            last_msg_reg <= bumped_msg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_total_reg <= '0;
            sig_total_reg <= '0;
            pay_valid_reg <= '0;
        end
        else
        begin
            if (do_msg)
            begin
                msg_total_reg <= msg_total_reg + 1'b1;
            end
            if (do_sig)
            begin
                sig_total_reg <= sig_total_reg + 7'd1;
            end
            if (do_load)
            begin
                pay_valid_reg[position[PAW-1:0]] <= 1'b1;
            end
        end
    end

endmodule

### rtl/csd_back.sv
// Back end: searches the message table, extracts signal bits one a cycle,
// scales with a shared 32x32 multiplier and buffers results.
// Depends on csd_pkg and csd_ram.
module csd_back import csd_pkg::*; #(
    parameter int MAX_MESSAGES  = DEF_MAX_MESSAGES,
    parameter int MAX_SIGNALS   = DEF_MAX_SIGNALS,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES,
    parameter int MTW = $clog2(MAX_MESSAGES + 1),
    parameter int MAW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1,
    parameter int SAW = (MAX_SIGNALS > 1) ? $clog2(MAX_SIGNALS) : 1,
    parameter int PNW = PAYLOAD_BYTES / 8,
    parameter int PAW = (PNW > 1) ? $clog2(PNW) : 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  req_t            q_data,
    output logic            q_pop,
    input  logic [MTW-1:0]  msg_total,
    output logic [MAW-1:0]  msg_raddr,
    input  msg_t            msg_rdata,
    output logic [SAW-1:0]  sig_raddr,
    input  sig_rec_t        sig_rdata,
    input  logic [PNW-1:0]  pay_valid,
    output logic [PAW-1:0]  pay_raddr,
    input  logic [63:0]     pay_rdata,
    output logic            idle,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [5:0]      signal_index,
    output logic [63:0]     value,
    output logic [2:0]      status,
    output logic            last
);

    back_state_t    state_reg, state_next;
    req_t           req_reg;
    logic [MTW-1:0] mi_reg;
    logic [5:0]     first_reg;
    logic [6:0]     count_reg;
    logic [6:0]     j_reg;
    logic           pass2_reg;
    logic [63:0]    sel_reg;
    logic [6:0]     n_reg;
    logic [6:0]     k_reg;
    sig_t           lay_reg;
    logic [63:0]    fac_reg;
    logic [63:0]    off_reg;
    logic [6:0]     w_reg;
    logic [10:0]    pos_reg;
    logic [6:0]     fi_reg;
    logic           pv_reg;
    logic [5:0]     pbit_reg;
    logic           pok_reg;
    logic [5:0]     pi_reg;
    logic [63:0]    raw_reg;
    logic [63:0]    rmag_reg;
    logic [63:0]    fmag_reg;
    logic           neg_reg;
    logic [2:0]     step_reg;
    logic [63:0]    prod_reg;
    logic [127:0]   acc_reg;
    logic [2:0]     emit_stat_reg;
    logic [5:0]     emit_idx_reg;
    logic           out_valid_reg;
    logic [5:0]     out_idx_reg;
    logic [63:0]    out_val_reg;
    logic [2:0]     out_stat_reg;
    logic           out_last_reg;

    logic           match;
    logic           last_msg;
    logic [7:0]     sig_sum;
    logic           sig_in;
    logic           skip;
    logic           issue;
    logic           fetch_done;
    logic           pok_c;
    logic           bit_c;
    logic [10:0]    pos_step;
    logic [6:0]     wm1;
    logic           sneg;
    logic [63:0]    mask;
    logic [63:0]    rmag_c;
    logic [63:0]    fmag_c;
    logic [31:0]    mul_a;
    logic [31:0]    mul_b;
    logic [2:0]     prev_step;
    logic [127:0]   sum_c;
    logic           ovf;
    logic           out_free;
    logic           out_load;
    logic           emit_last;
    logic           res_we;
    logic [69:0]    res_rdata;

    // ---- combinational datapath ----
    assign match    = (msg_rdata.id == req_reg.id) && (msg_rdata.ext == req_reg.ext);
    assign last_msg = (MTW'(mi_reg + 1'b1) == msg_total);
    assign sig_sum  = {2'b00, first_reg} + {1'b0, j_reg};
    assign sig_in   = (j_reg < count_reg) && (sig_sum < MAX_SIGNALS);

    always_comb
    begin
        if (!pass2_reg)
        begin
            skip = (sig_rdata.layout.role != ROLE_SELECTOR);
        end
        else
        begin
            skip = (sig_rdata.layout.role == ROLE_MUXED)
                   && ({47'd0, sig_rdata.layout.mux_value} != sel_reg);
        end
    end

    assign issue      = (fi_reg < w_reg);
    assign fetch_done = !issue && !pv_reg;
    assign pok_c      = ({1'b0, pos_reg[10:3]} < PAYLOAD_BYTES)
                        && ({27'd0, pos_reg[10:6]} < PNW)
                        && pay_valid[pos_reg[PAW+5:6]];
    assign bit_c      = pok_reg && pay_rdata[pbit_reg];
    assign pos_step   = lay_reg.lsb_first ? pos_reg + 11'd1 :
                        (pos_reg[2:0] != 3'd0) ? pos_reg - 11'd1 : pos_reg + MOTO_JUMP;

    assign wm1    = w_reg - 7'd1;
    assign sneg   = lay_reg.is_signed && (w_reg != 7'd0) && raw_reg[wm1[5:0]];
    assign mask   = w_reg[6] ? {64{1'b1}} : ((64'd1 << w_reg[5:0]) - 64'd1);
    assign rmag_c = sneg ? ((64'd0 - raw_reg) & mask) : raw_reg;
    assign fmag_c = fac_reg[63] ? (64'd0 - fac_reg) : fac_reg;

    assign mul_a     = step_reg[1] ? rmag_reg[63:32] : rmag_reg[31:0];
    assign mul_b     = step_reg[0] ? fmag_reg[63:32] : fmag_reg[31:0];
    assign prev_step = step_reg - 3'd1;

    assign sum_c = acc_reg + {{64{off_reg[63]}}, off_reg};
    assign ovf   = (sum_c[127:64] != {64{sum_c[63]}});

    assign out_free  = !out_valid_reg || out_ready;
    assign emit_last = (7'(k_reg + 7'd1) == n_reg);

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (msg_total == '0) ? ST_EMIT_ONE : ST_MSG_RD;
                end
            end
            ST_MSG_RD:   state_next = ST_MSG_CMP;
            ST_MSG_CMP:
            begin
                if (match)
                begin
                    state_next = (req_reg.len < msg_rdata.len) ? ST_EMIT_ONE : ST_SIG_CHK;
                end
                else
                begin
                    state_next = last_msg ? ST_EMIT_ONE : ST_MSG_RD;
                end
            end
            ST_SIG_CHK:
            begin
                if (sig_in)
                begin
                    state_next = ST_SIG_WAIT;
                end
                else if (pass2_reg)
                begin
                    state_next = (n_reg == 7'd0) ? ST_EMIT_ONE : ST_EMIT_RD;
                end
            end
            ST_SIG_WAIT: state_next = skip ? ST_SIG_CHK : ST_FETCH;
            ST_FETCH:
            begin
                if (fetch_done)
                begin
                    state_next = pass2_reg ? ST_MUL : ST_SIG_CHK;
                end
            end
            ST_MUL:      state_next = (step_reg == 3'd4) ? ST_NEG : ST_MUL;
            ST_NEG:      state_next = ST_ADD;
            ST_ADD:      state_next = ovf ? ST_EMIT_ONE : ST_SIG_CHK;
            ST_EMIT_ONE: state_next = out_free ? ST_IDLE : ST_EMIT_ONE;
            ST_EMIT_RD:  state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---- outputs of the sequencer ----
    always_comb
    begin
        q_pop    = 1'b0;
        res_we   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:     q_pop    = !q_empty;
            ST_ADD:      res_we   = !ovf;
            ST_EMIT_ONE: out_load = out_free;
            ST_EMIT_OUT: out_load = out_free;
            default:     q_pop    = 1'b0;
        endcase
    end

    assign idle      = (state_reg == ST_IDLE);
    assign msg_raddr = mi_reg[MAW-1:0];
    assign sig_raddr = sig_sum[SAW-1:0];
    assign pay_raddr = pos_reg[PAW+5:6];

    csd_ram #(.WIDTH(70), .DEPTH(MAX_SIGNALS)) u_result_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (n_reg[SAW-1:0]),
        .wdata ({j_reg[5:0], sum_c[63:0]}),
        .raddr (k_reg[SAW-1:0]),
        .rdata (res_rdata)
    );

    // ---- datapath registers ----
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                req_reg       <= q_data;
                mi_reg        <= '0;
                emit_stat_reg <= STAT_UNKNOWN;
                emit_idx_reg  <= 6'd0;
            end
            ST_MSG_CMP:
            begin
                mi_reg    <= mi_reg + 1'b1;
                first_reg <= msg_rdata.first;
                count_reg <= msg_rdata.count;
                j_reg     <= 7'd0;
                pass2_reg <= 1'b0;
                sel_reg   <= 64'd0;
                n_reg     <= 7'd0;
                if (match)
                begin
                    emit_stat_reg <= STAT_SHORT;
                end
            end
            ST_SIG_CHK:
            begin
                // switch to the value pass once selectors are read
                if (!sig_in && !pass2_reg)
                begin
                    pass2_reg <= 1'b1;
                    j_reg     <= 7'd0;
                end
                emit_stat_reg <= STAT_NOSIG;
                k_reg         <= 7'd0;
            end
            ST_SIG_WAIT:
            begin
                lay_reg  <= sig_rdata.layout;
                fac_reg  <= sig_rdata.factor;
                off_reg  <= sig_rdata.offset;
                w_reg    <= (sig_rdata.layout.width > 7'd64) ? 7'd64 : sig_rdata.layout.width;
                pos_reg  <= {2'b00, sig_rdata.layout.pos};
                fi_reg   <= 7'd0;
                pv_reg   <= 1'b0;
                raw_reg  <= 64'd0;
                if (skip)
                begin
                    j_reg <= j_reg + 7'd1;
                end
            end
            ST_FETCH:
            begin
                pv_reg   <= issue;
                pbit_reg <= pos_reg[5:0];
                pok_reg  <= pok_c;
                pi_reg   <= fi_reg[5:0];
                if (issue)
                begin
                    pos_reg <= pos_step;
                    fi_reg  <= fi_reg + 7'd1;
                end
                if (pv_reg)
                begin
                    raw_reg <= lay_reg.lsb_first ? (raw_reg | (64'(bit_c) << pi_reg))
                                                 : {raw_reg[62:0], bit_c};
                end
                if (fetch_done)
                begin
                    rmag_reg <= rmag_c;
                    fmag_reg <= fmag_c;
                    neg_reg  <= sneg ^ fac_reg[63];
                    step_reg <= 3'd0;
                    acc_reg  <= 128'd0;
                    if (!pass2_reg)
                    begin
                        sel_reg <= raw_reg;
                        j_reg   <= j_reg + 7'd1;
                    end
                end
            end
            ST_MUL:
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg != 3'd4)
                begin
                    prod_reg <= mul_a * mul_b;
                end
                if (step_reg != 3'd0)
                begin
                    case (prev_step)
                        3'd0:    acc_reg <= acc_reg + {64'd0, prod_reg};
                        3'd3:    acc_reg <= acc_reg + {prod_reg, 64'd0};
                        default: acc_reg <= acc_reg + {32'd0, prod_reg, 32'd0};
                    endcase
                end
            end
            ST_NEG:
            begin
                if (neg_reg)
                begin
                    acc_reg <= 128'd0 - acc_reg;
                end
            end
            ST_ADD:
            begin
                emit_stat_reg <= STAT_OVF;
                emit_idx_reg  <= j_reg[5:0];
                if (!ovf)
                begin
                    n_reg <= n_reg + 7'd1;
                    j_reg <= j_reg + 7'd1;
                end
            end
            ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    k_reg <= k_reg + 7'd1;
                end
            end
            default:
            begin
                pv_reg <= 1'b0;
            end
        endcase

        if (out_load)
        begin
            if (state_reg == ST_EMIT_OUT)
            begin
                out_idx_reg  <= res_rdata[69:64];
                out_val_reg  <= res_rdata[63:0];
                out_stat_reg <= STAT_VALUE;
                out_last_reg <= emit_last;
            end
            else
            begin
                out_idx_reg  <= emit_idx_reg;
                out_val_reg  <= 64'd0;
                out_stat_reg <= emit_stat_reg;
                out_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign signal_index = out_idx_reg;
    assign value        = out_val_reg;
    assign status       = out_stat_reg;
    assign last         = out_last_reg;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_stat_reg != STAT_VALUE)) |-> out_last_reg)
        else $error("error result not marked last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_stat_reg != STAT_VALUE)) |-> (out_val_reg == 64'd0))
        else $error("error result carries a value");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_OUT) |-> ((n_reg != 7'd0) && (k_reg < n_reg)))
        else $error("result buffer read past fill");

endmodule

### rtl/can_signal_decoder.sv
// Top level of the CAN signal decoder: front end, request queue, back end
// and the table memories. Depends on csd_pkg, csd_ram, csd_queue,
// csd_front, csd_back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  input   | in        | in_valid / in_ready  | op, frame_id ... wide_value, offset
//  result  | out       | out_valid / out_ready| signal_index, value, status, last
//
// Define, signal and load items wait until no decode is pending. A decode item
// is queued at once (two deep) while the queue has room; the back end then
// searches the message entries, visits the signals in each of two passes,
// extracts signal bits one payload bit a cycle from the payload RAM and scales
// each value-pass signal with four 32x32 partial products on one multiplier,
// then emits the result items. Reset clears totals, valid bits of the payload
// words and control; tables need no clearing. A stalled result output holds
// the back end; the front keeps queueing decodes meanwhile.
module can_signal_decoder import csd_pkg::*; #(
    parameter int MAX_MESSAGES  = DEF_MAX_MESSAGES,
    parameter int MAX_SIGNALS   = DEF_MAX_SIGNALS,
    parameter int PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [28:0] frame_id,
    input  logic        extended,
    input  logic [6:0]  byte_count,
    input  logic [8:0]  position,
    input  logic [6:0]  bit_count,
    input  logic        little_endian,
    input  logic        is_signed,
    input  logic [1:0]  mux_role,
    input  logic [16:0] mux_value,
    input  logic signed [63:0] wide_value,
    input  logic signed [63:0] offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  signal_index,
    output logic signed [63:0] value,
    output logic [2:0]  status,
    output logic        last
);

    localparam int MTW = $clog2(MAX_MESSAGES + 1);
    localparam int MAW = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
    localparam int SAW = (MAX_SIGNALS > 1) ? $clog2(MAX_SIGNALS) : 1;
    localparam int PNW = PAYLOAD_BYTES / 8;
    localparam int PAW = (PNW > 1) ? $clog2(PNW) : 1;

    // request queue
    logic q_push, q_pop, q_full, q_empty;
    req_t q_wdata, q_rdata;

    // table memories
    logic           msg_we;
    logic [MAW-1:0] msg_waddr, msg_raddr;
    msg_t           msg_wdata, msg_rdata;
    logic           sig_we;
    logic [SAW-1:0] sig_waddr, sig_raddr;
    sig_rec_t       sig_wdata, sig_rdata;
    logic           pay_we;
    logic [PAW-1:0] pay_waddr, pay_raddr;
    logic [63:0]    pay_wdata, pay_rdata;
    logic [PNW-1:0] pay_valid;
    logic [MTW-1:0] msg_total;
    logic           back_idle;
    logic [63:0]    value_u;

    csd_front #(
        .MAX_MESSAGES (MAX_MESSAGES),
        .MAX_SIGNALS  (MAX_SIGNALS),
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .frame_id     (frame_id),
        .extended     (extended),
        .byte_count   (byte_count),
        .position     (position),
        .bit_count    (bit_count),
        .little_endian(little_endian),
        .is_signed    (is_signed),
        .mux_role     (mux_role),
        .mux_value    (mux_value),
        .wide_value   (wide_value),
        .offset       (offset),
        .q_full       (q_full),
        .q_empty      (q_empty),
        .back_idle    (back_idle),
        .q_push       (q_push),
        .q_wdata      (q_wdata),
        .msg_we       (msg_we),
        .msg_waddr    (msg_waddr),
        .msg_wdata    (msg_wdata),
        .sig_we       (sig_we),
        .sig_waddr    (sig_waddr),
        .sig_wdata    (sig_wdata),
        .pay_we       (pay_we),
        .pay_waddr    (pay_waddr),
        .pay_wdata    (pay_wdata),
        .pay_valid    (pay_valid),
        .msg_total    (msg_total)
    );

    csd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    csd_ram #(.WIDTH($bits(msg_t)), .DEPTH(MAX_MESSAGES)) u_msg_ram (
        .clk   (clk),
        .we    (msg_we),
        .waddr (msg_waddr),
        .wdata (msg_wdata),
        .raddr (msg_raddr),
        .rdata (msg_rdata)
    );

    csd_ram #(.WIDTH($bits(sig_rec_t)), .DEPTH(MAX_SIGNALS)) u_sig_ram (
        .clk   (clk),
        .we    (sig_we),
        .waddr (sig_waddr),
        .wdata (sig_wdata),
        .raddr (sig_raddr),
        .rdata (sig_rdata)
    );

    // eight payload bytes per word, lowest byte in the low bits
    csd_ram #(.WIDTH(64), .DEPTH(PNW)) u_pay_ram (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (pay_wdata),
        .raddr (pay_raddr),
        .rdata (pay_rdata)
    );

    csd_back #(
        .MAX_MESSAGES (MAX_MESSAGES),
        .MAX_SIGNALS  (MAX_SIGNALS),
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .msg_total   (msg_total),
        .msg_raddr   (msg_raddr),
        .msg_rdata   (msg_rdata),
        .sig_raddr   (sig_raddr),
        .sig_rdata   (sig_rdata),
        .pay_valid   (pay_valid),
        .pay_raddr   (pay_raddr),
        .pay_rdata   (pay_rdata),
        .idle        (back_idle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .signal_index(signal_index),
        .value       (value_u),
        .status      (status),
        .last        (last)
    );

    assign value = value_u;

endmodule

### verif/tb.sv
// Self-checking testbench for can_signal_decoder: a queue-fed driver, a
// result monitor and a built-in predictor of the table and decode behavior.
// Depends on csd_pkg and the RTL of can_signal_decoder.
`timescale 1ns / 1ps

module tb;
    import csd_pkg::*;

    localparam logic [63:0] Q_ONE  = 64'h0000_0001_0000_0000;
    localparam logic [63:0] Q_HALF = 64'h0000_0000_8000_0000;
    localparam int          CYCLE_LIMIT = 10000000;

    // One pending input item; hold_for_drain marks a pause until all
    // expected results are back, and carries no item.
    typedef struct {
        logic [1:0]  op;
        logic [28:0] id;
        logic        ext;
        logic [6:0]  len;
        logic [8:0]  pos;
        logic [6:0]  bits;
        logic        lsb;
        logic        sgn;
        logic [1:0]  role;
        logic [16:0] mv;
        logic [63:0] wide;
        logic [63:0] ofs;
        bit          hold_for_drain;
    } can_item_t;

    typedef struct {
        logic [5:0]  idx;
        logic [63:0] val;
        logic [2:0]  st;
        logic        lst;
    } decoded_t;

    logic clk;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = OP_DEF_MSG;
    logic [28:0] frame_id = '0;
    logic        extended = 1'b0;
    logic [6:0]  byte_count = '0;
    logic [8:0]  position = '0;
    logic [6:0]  bit_count = '0;
    logic        little_endian = 1'b0;
    logic        is_signed = 1'b0;
    logic [1:0]  mux_role = '0;
    logic [16:0] mux_value = '0;
    logic signed [63:0] wide_value = '0;
    logic signed [63:0] offset = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  signal_index;
    logic signed [63:0] value;
    logic [2:0]  status;
    logic        last;

    can_signal_decoder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .frame_id(frame_id), .extended(extended),
        .byte_count(byte_count), .position(position), .bit_count(bit_count),
        .little_endian(little_endian), .is_signed(is_signed),
        .mux_role(mux_role), .mux_value(mux_value),
        .wide_value(wide_value), .offset(offset),
        .out_valid(out_valid), .out_ready(out_ready),
        .signal_index(signal_index), .value(value),
        .status(status), .last(last)
    );

    // Clock: 20 ns period
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the decoder's tables
    // ------------------------------------------------------------------
    msg_t     msg_tab [DEF_MAX_MESSAGES];
    int       msg_cnt = 0;
    sig_rec_t sig_tab [DEF_MAX_SIGNALS];
    int       sig_cnt = 0;
    logic [7:0] pay_mem [DEF_PAYLOAD_BYTES];

    can_item_t pending_items[$];
    decoded_t  expected_results[$];
    int        error_count = 0;
    int        items_accepted = 0;
    bit        quiet_tail = 0;     // no idling on either side near the end
    int        hold_left = 0;      // long receiver hold-off, in cycles
    bit        hold_done = 0;

    // Gather a signal's raw bits, Intel or Motorola order; bits beyond
    // the payload store read as zero.
    function automatic logic [63:0] gather_raw(sig_t s);
        int unsigned p, w, i;
        logic [63:0] r;
        logic b;
        p = s.pos;
        w = (s.width > 64) ? 64 : s.width;
        r = '0;
        for (i = 0; i < w; i++)
        begin
            b = ((p >> 3) < DEF_PAYLOAD_BYTES) ? pay_mem[p >> 3][p & 7] : 1'b0;
            if (s.lsb_first)
                r[i] = b;
            else
                r = {r[62:0], b};
            if (s.lsb_first)
                p = p + 1;
            else if (p % 8)
                p = p - 1;
            else
                p = p + 15;
        end
        return r;
    endfunction

    // raw * factor + offset in Q32.32; returns 0 when out of 64-bit range
    function automatic bit scale_raw(sig_rec_t rec, logic [63:0] raw,
                                     output logic [63:0] res);
        int unsigned w;
        logic signed [129:0] rv, fv, ov, t;
        w = (rec.layout.width > 64) ? 64 : rec.layout.width;
        rv = {66'b0, raw};
        if (rec.layout.is_signed && w > 0 && raw[w-1])
            rv = rv - (130'sd1 <<< w);
        fv = {{66{rec.factor[63]}}, rec.factor};
        ov = {{66{rec.offset[63]}}, rec.offset};
        t = rv * fv + ov;
        res = t[63:0];
        return (t[129:63] == '0) || (t[129:63] == '1);
    endfunction

    function automatic void add_result(logic [5:0] i, logic [63:0] v,
                                       logic [2:0] s, logic l);
        decoded_t d;
        d.idx = i; d.val = v; d.st = s; d.lst = l;
        expected_results.push_back(d);
    endfunction

    // Update the shadow tables for one accepted item and queue what it yields
    function automatic void predict_item(can_item_t it);
        msg_t m;
        sig_rec_t rec;
        logic [63:0] sel, v;
        decoded_t found_vals[$];
        decoded_t d;
        int mi, j, hit;
        case (it.op)
            OP_DEF_MSG:
            begin
                if (msg_cnt < DEF_MAX_MESSAGES)
                begin
                    m.id = it.id; m.ext = it.ext; m.len = it.len;
                    m.first = sig_cnt[5:0]; m.count = '0;
                    msg_tab[msg_cnt] = m;
                    msg_cnt++;
                end
            end
            OP_DEF_SIG:
            begin
                if (msg_cnt != 0 && sig_cnt < DEF_MAX_SIGNALS)
                begin
                    rec.layout.pos = it.pos; rec.layout.width = it.bits;
                    rec.layout.lsb_first = it.lsb; rec.layout.is_signed = it.sgn;
                    rec.layout.role = it.role; rec.layout.mux_value = it.mv;
                    rec.factor = it.wide; rec.offset = it.ofs;
                    sig_tab[sig_cnt] = rec;
                    sig_cnt++;
                    msg_tab[msg_cnt-1].count = msg_tab[msg_cnt-1].count + 7'd1;
                end
            end
            OP_LOAD:
            begin
                if (it.pos * 8 + 8 <= DEF_PAYLOAD_BYTES)
                    for (j = 0; j < 8; j++)
                        pay_mem[it.pos*8 + j] = it.wide[8*j +: 8];
            end
            default:
            begin
                hit = -1;
                for (mi = 0; mi < msg_cnt; mi++)
                    if (hit < 0 && msg_tab[mi].id == it.id && msg_tab[mi].ext == it.ext)
                        hit = mi;
                if (hit < 0)
                begin
                    add_result(6'd0, 64'd0, STAT_UNKNOWN, 1'b1);
                    return;
                end
                m = msg_tab[hit];
                if (it.len < m.len)
                begin
                    add_result(6'd0, 64'd0, STAT_SHORT, 1'b1);
                    return;
                end
                // the last selector wins
                sel = '0;
                for (j = 0; j < m.count && m.first + j < DEF_MAX_SIGNALS; j++)
                    if (sig_tab[m.first + j].layout.role == ROLE_SELECTOR)
                        sel = gather_raw(sig_tab[m.first + j].layout);
                for (j = 0; j < m.count && m.first + j < DEF_MAX_SIGNALS; j++)
                begin
                    rec = sig_tab[m.first + j];
                    if (rec.layout.role == ROLE_MUXED && {47'b0, rec.layout.mux_value} != sel)
                        continue;
                    if (!scale_raw(rec, gather_raw(rec.layout), v))
                    begin
                        add_result(j[5:0], 64'd0, STAT_OVF, 1'b1);
                        return;
                    end
                    d.idx = j[5:0]; d.val = v; d.st = STAT_VALUE; d.lst = 1'b0;
                    found_vals.push_back(d);
                end
                if (found_vals.size() == 0)
                begin
                    add_result(6'd0, 64'd0, STAT_NOSIG, 1'b1);
                    return;
                end
                found_vals[found_vals.size()-1].lst = 1'b1;
                foreach (found_vals[k])
                    expected_results.push_back(found_vals[k]);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic can_item_t blank_item(logic [1:0] o);
        can_item_t it;
        it.op = o; it.id = '0; it.ext = 1'b0; it.len = '0; it.pos = '0;
        it.bits = '0; it.lsb = 1'b0; it.sgn = 1'b0; it.role = '0; it.mv = '0;
        it.wide = '0; it.ofs = '0; it.hold_for_drain = 0;
        return it;
    endfunction

    function automatic void push_msg(logic [28:0] id, logic ext, logic [6:0] len);
        can_item_t it;
        it = blank_item(OP_DEF_MSG);
        it.id = id; it.ext = ext; it.len = len;
        // leave the unused pos and wide fields random so their bits toggle
        it.pos = 9'($urandom); it.wide = {$urandom, $urandom};
        pending_items.push_back(it);
    endfunction

    function automatic void push_sig(logic [8:0] pos, logic [6:0] bits, logic lsb,
                                     logic sgn, logic [1:0] role, logic [16:0] mv,
                                     logic [63:0] fac, logic [63:0] ofs);
        can_item_t it;
        it = blank_item(OP_DEF_SIG);
        it.pos = pos; it.bits = bits; it.lsb = lsb; it.sgn = sgn;
        it.role = role; it.mv = mv; it.wide = fac; it.ofs = ofs;
        it.id = 29'($urandom); it.len = 7'($urandom);
        pending_items.push_back(it);
    endfunction

    function automatic void push_load(logic [8:0] word_idx, logic [63:0] data);
        can_item_t it;
        it = blank_item(OP_LOAD);
        it.pos = word_idx; it.wide = data;
        pending_items.push_back(it);
    endfunction

    function automatic void push_decode(logic [28:0] id, logic ext, logic [6:0] len);
        can_item_t it;
        it = blank_item(OP_DECODE);
        it.id = id; it.ext = ext; it.len = len;
        it.bits = 7'($urandom); it.mv = 17'($urandom); it.ofs = {$urandom, $urandom};
        pending_items.push_back(it);
    endfunction

    function automatic void push_drain();
        can_item_t it;
        it = blank_item(OP_DEF_MSG);
        it.hold_for_drain = 1;
        pending_items.push_back(it);
    endfunction

    function automatic logic [63:0] rand_q3232();
        case ($urandom_range(0, 3))
            0: return Q_ONE;
            1: return {{16{1'b0}}, 16'($urandom_range(0, 65535)), 32'($urandom)} -
                      64'h0000_8000_0000_0000;
            2: return {{32{1'b0}}, 32'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: present one item at a time, predict on acceptance
    // ------------------------------------------------------------------
    can_item_t cur_item;
    int        idle_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        can_item_t nxt;
        bit drive_new;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            drive_new = 0;
            if (in_valid && in_ready)
            begin
                predict_item(cur_item);
                items_accepted++;
            end
            if (in_valid && !in_ready)
            begin
                // hold the item until it is taken
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (pending_items[0].hold_for_drain)
            begin
                // pause the sender until every result is back
                if (expected_results.size() == 0)
                    void'(pending_items.pop_front());
                in_valid <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                idle_left = $urandom_range(1, 8) - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                drive_new = 1;
            end
            if (drive_new)
            begin
                nxt = pending_items.pop_front();
                cur_item = nxt;
                in_valid      <= 1'b1;
                op            <= nxt.op;
                frame_id      <= nxt.id;
                extended      <= nxt.ext;
                byte_count    <= nxt.len;
                position      <= nxt.pos;
                bit_count     <= nxt.bits;
                little_endian <= nxt.lsb;
                is_signed     <= nxt.sgn;
                mux_role      <= nxt.role;
                mux_value     <= nxt.mv;
                wide_value    <= nxt.wide;
                offset        <= nxt.ofs;
            end
            if (pending_items.size() < 40)
                quiet_tail = 1;
        end
    end

    // Long receiver hold-off once the run is well under way
    always @(posedge clk)
    begin
        if (!hold_done && items_accepted >= 150)
        begin
            hold_done <= 1;
            hold_left <= 600;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest expectation
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: index %0d value %h status %0d",
                           signal_index, value, status);
                    error_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (signal_index !== e.idx)
                    begin
                        $error("signal_index: expected %0d, actual %0d", e.idx, signal_index);
                        error_count++;
                    end
                    if (value !== e.val)
                    begin
                        $error("value: expected %h, actual %h", e.val, value);
                        error_count++;
                    end
                    if (status !== e.st)
                    begin
                        $error("status: expected %0d, actual %0d", e.st, status);
                        error_count++;
                    end
                    if (last !== e.lst)
                    begin
                        $error("last: expected %0d, actual %0d", e.lst, last);
                        error_count++;
                    end
                end
            end
            // random stall bursts, none near the end
            if (stall_left > 0)
                stall_left--;
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 8);
            out_ready <= (stall_left == 0) && (hold_left == 0);
        end
    end

    // Timeout guard
    int cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [28:0] ids [$];
        logic        exts [$];
        logic [6:0]  lens [$];
        logic [28:0] rid;
        logic        rext;
        int          n, pick;

        foreach (pay_mem[i])
            pay_mem[i] = 8'h00;

        // Directed: empty table, every signal flavor, every status
        push_decode(29'h5, 1'b0, 7'd8);                                // unknown, empty table
        push_msg(29'h123, 1'b0, 7'd8);
        push_sig(9'd0, 7'd8, 1'b1, 1'b0, 2'd0, 17'd0, Q_ONE, 64'd0);   // plain Intel
        push_sig(9'd7, 7'd12, 1'b0, 1'b1, 2'd0, 17'd0, Q_ONE,
                 64'hFFFF_FFFE_8000_0000);                             // Motorola signed
        push_sig(9'd16, 7'd4, 1'b1, 1'b0, ROLE_SELECTOR, 17'd0, Q_ONE, 64'd0);
        push_sig(9'd20, 7'd8, 1'b1, 1'b1, ROLE_MUXED, 17'd3, Q_HALF, 64'd0);  // present
        push_sig(9'd20, 7'd8, 1'b1, 1'b0, ROLE_MUXED, 17'h1FFFF, Q_ONE, 64'd0); // absent
        push_sig(9'd24, 7'd0, 1'b1, 1'b1, 2'd0, 17'd0, Q_ONE, 64'd7);  // width zero
        push_sig(9'd0, 7'd127, 1'b1, 1'b1, 2'd3, 17'd0, 64'd1, 64'd0); // wide, role 3
        push_load(9'd0, 64'hFEDC_BA98_7653_A5F1);
        push_load(9'd9, 64'hFFFF_FFFF_FFFF_FFFF);                      // beyond store
        push_load(9'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        push_decode(29'h123, 1'b0, 7'd7);                              // short
        push_decode(29'h123, 1'b0, 7'd64);
        push_decode(29'h123, 1'b1, 7'd8);                              // ext mismatch
        push_msg(29'h1FFF_FFFF, 1'b1, 7'd0);
        push_decode(29'h1FFF_FFFF, 1'b1, 7'd0);                        // no signals
        push_msg(29'h123, 1'b0, 7'd0);                                 // duplicate
        push_decode(29'h123, 1'b0, 7'd127);
        push_msg(29'h55, 1'b0, 7'd64);
        push_sig(9'd505, 7'd16, 1'b0, 1'b0, 2'd0, 17'd0, Q_ONE, 64'd0); // runs off store
        push_sig(9'd0, 7'd64, 1'b1, 1'b1, 2'd0, 17'd0, 64'h8000_0000_0000_0000,
                 64'h8000_0000_0000_0000);                             // overflow
        push_decode(29'h55, 1'b0, 7'd64);
        push_drain();

        ids.push_back(29'h123); exts.push_back(1'b0); lens.push_back(7'd8);
        ids.push_back(29'h55);  exts.push_back(1'b0); lens.push_back(7'd64);

        // Random: build messages and signals, load payloads, decode them
        for (n = 0; n < 280; n++)
        begin
            if (n == 140)
                push_drain();
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                rext = 1'($urandom_range(0, 1));
                rid = rext ? 29'($urandom) : 29'($urandom_range(0, 2047));
                lens.push_back($urandom_range(0, 3) == 0 ? 7'($urandom) :
                               7'($urandom_range(0, 64)));
                ids.push_back(rid); exts.push_back(rext);
                push_msg(rid, rext, lens[lens.size()-1]);
            end
            else if (pick < 35)
            begin
                push_sig($urandom_range(0, 3) == 0 ? 9'($urandom) : 9'($urandom_range(0, 63)),
                         $urandom_range(0, 4) == 0 ? 7'($urandom) : 7'($urandom_range(1, 16)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)),
                         $urandom_range(0, 4) == 0 ? 17'($urandom) : 17'($urandom_range(0, 15)),
                         rand_q3232(), rand_q3232());
            end
            else if (pick < 55)
            begin
                push_load($urandom_range(0, 5) == 0 ? 9'($urandom) : 9'($urandom_range(0, 7)),
                          {$urandom, $urandom});
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    push_decode(29'($urandom), 1'($urandom_range(0, 1)), 7'($urandom));
                end
                else
                begin
                    pick = $urandom_range(0, ids.size() - 1);
                    push_decode(ids[pick], exts[pick],
                                $urandom_range(0, 6) == 0 ? 7'($urandom) :
                                7'($urandom_range(lens[pick], 127)));
                end
            end
        end

        // Hold reset, then release it once
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all items sent, all results back, then a settling margin
        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/csd_pkg.sv
rtl/csd_ram.sv
rtl/csd_queue.sv
rtl/csd_front.sv
rtl/csd_back.sv
rtl/can_signal_decoder.sv
verif/tb.sv
